FILE: rtl/hwt_pkg.sv
// shared types and codes for the hashed timer wheel
`default_nettype none

package hwt_pkg;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int DELAY_W  = 6;
  localparam int HANDLE_W = 5;
  localparam int STATUS_W = 3;

  // number of distinct delay codes
  localparam int DELAY_RANGE = 1 << DELAY_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ARMED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_EXPIRY = 3'd5;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } state_t;

  // per-cycle command broadcast to every timer cell
  typedef struct packed {
    logic add_en;
    logic stop_en;
    logic tick_en;
    logic emit_en;
    logic rep;
  } cell_ctrl_t;

  // priority chain passed from one cell to the next
  typedef struct packed {
    logic free_seen;
    logic due_seen;
  } chain_t;

  // status reported by each cell to the sequencer
  typedef struct packed {
    logic claim;
    logic stop_hit;
    logic hit_now;
    logic due;
    logic due_pick;
    logic due_rest;
  } cell_stat_t;

endpackage

`default_nettype wire

FILE: rtl/hwt_cell.sv
// one timer cell: holds a single timer and passes the priority chain on
`default_nettype none

module hwt_cell #(
  parameter int WHEEL_SIZE = 64,
  parameter int IDX        = 0
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire hwt_pkg::cell_ctrl_t              ctrl,
  input  wire logic [hwt_pkg::HANDLE_W-1:0]     handle,
  input  wire logic [$clog2(WHEEL_SIZE)-1:0]    add_slot,
  input  wire logic [$clog2(WHEEL_SIZE)-1:0]    add_period,
  input  wire logic [$clog2(WHEEL_SIZE)-1:0]    pos,
  input  wire logic [$clog2(WHEEL_SIZE)-1:0]    pos_next,
  input  wire hwt_pkg::chain_t                  chain_in,
  output hwt_pkg::chain_t                       chain_out,
  output hwt_pkg::cell_stat_t                   stat
);

  localparam int SLOT_W = $clog2(WHEEL_SIZE);
  localparam bit ADDRESSABLE = IDX < (1 << hwt_pkg::HANDLE_W);

  logic              in_use;
  logic              due;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] period;
  logic              repeats;

  logic              claim;
  logic              hit_now;
  logic              due_pick;
  logic              stop_hit;
  logic [SLOT_W:0]   rearm_sum;
  logic [SLOT_W-1:0] rearm_slot;

  // priority chain: lowest free cell and lowest due cell win
  assign claim               = !in_use && !chain_in.free_seen;
  assign due_pick            = due && !chain_in.due_seen;
  assign chain_out.free_seen = chain_in.free_seen || !in_use;
  assign chain_out.due_seen  = chain_in.due_seen || due;

  // match against the stop handle and the current wheel slot
  assign stop_hit = ADDRESSABLE && in_use && (handle == hwt_pkg::HANDLE_W'(IDX));
  assign hit_now  = in_use && (slot == pos);

  // re-arm slot: period past the position after the current one, modulo the wheel size
  assign rearm_sum  = {1'b0, pos_next} + {1'b0, period};
  assign rearm_slot = (rearm_sum >= (SLOT_W+1)'(WHEEL_SIZE)) ?
                      SLOT_W'(rearm_sum - (SLOT_W+1)'(WHEEL_SIZE)) : SLOT_W'(rearm_sum);

  assign stat.claim    = claim;
  assign stat.stop_hit = stop_hit;
  assign stat.hit_now  = hit_now;
  assign stat.due      = due;
  assign stat.due_pick = due_pick;
  assign stat.due_rest = due && chain_in.due_seen;

  // armed and pending flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= 1'b0;
      due    <= 1'b0;
    end else begin
      if (ctrl.add_en && claim) begin
        in_use <= 1'b1;
      end
      if (ctrl.stop_en && stop_hit) begin
        in_use <= 1'b0;
      end
      if (ctrl.tick_en && hit_now) begin
        due <= 1'b1;
        if (!repeats) begin
          in_use <= 1'b0;
        end
      end
      if (ctrl.emit_en && due_pick) begin
        due <= 1'b0;
      end
    end
  end

  // timer payload, written on add and on re-arm
  always_ff @(posedge clk) begin
    if (ctrl.add_en && claim) begin
      slot    <= add_slot;
      period  <= add_period;
      repeats <= ctrl.rep;
    end else if (ctrl.tick_en && hit_now && repeats) begin
      slot <= rearm_slot;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hashed_timer_wheel.sv
// top level of the hashed timer wheel: sequencer, output register and cell row
// add or stop: command registered, result loaded in execute state once output is free
// tick: wheel advances, then one result per cycle while the output is free
// one result per expiry with last on the final one, or one no-expiry result if none fired
// the output register lets a new item in while the last result still waits
// reset (synchronous): all timers free, nothing pending, wheel position zero
`default_nettype none

module hashed_timer_wheel #(
  parameter int NUM_TIMERS = 32,
  parameter int WHEEL_SIZE = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [hwt_pkg::OP_W-1:0]         op,
  input  wire logic [hwt_pkg::DELAY_W-1:0]      delay,
  input  wire logic                             repeat_req,
  input  wire logic [hwt_pkg::HANDLE_W-1:0]     handle,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [hwt_pkg::STATUS_W-1:0]          status,
  output logic [hwt_pkg::HANDLE_W-1:0]          timer_id,
  output logic                                  last
);

  localparam int SLOT_W = $clog2(WHEEL_SIZE);

  hwt_pkg::state_t state, state_next;

  logic [hwt_pkg::OP_W-1:0]     cmd_op;
  logic [hwt_pkg::DELAY_W-1:0]  cmd_delay;
  logic                         cmd_rep;
  logic [hwt_pkg::HANDLE_W-1:0] cmd_handle;
  logic [SLOT_W-1:0]            pos;
  logic [SLOT_W-1:0]            pos_next;
  logic                         tick_none;

  logic [SLOT_W-1:0]            dmod_tab [hwt_pkg::DELAY_RANGE];
  logic [SLOT_W-1:0]            dmod;
  logic [SLOT_W:0]              add_sum;
  logic [SLOT_W-1:0]            add_slot;

  hwt_pkg::cell_ctrl_t          ctrl;
  hwt_pkg::chain_t              chain [NUM_TIMERS+1];
  hwt_pkg::cell_stat_t          stat  [NUM_TIMERS];

  logic [NUM_TIMERS-1:0]        claim_vec;
  logic [NUM_TIMERS-1:0]        pick_vec;
  logic [NUM_TIMERS-1:0]        due_vec;
  logic [NUM_TIMERS-1:0]        rest_vec;
  logic [NUM_TIMERS-1:0]        hit_vec;
  logic [NUM_TIMERS-1:0]        stop_vec;
  logic [hwt_pkg::HANDLE_W-1:0] claim_id;
  logic [hwt_pkg::HANDLE_W-1:0] pick_id;

  logic                         in_xfer;
  logic                         out_free;
  logic                         out_load;
  logic [hwt_pkg::STATUS_W-1:0] res_status;
  logic [hwt_pkg::HANDLE_W-1:0] res_id;
  logic                         res_last;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // delay reduced modulo the wheel size, built at elaboration
  for (genvar g = 0; g < hwt_pkg::DELAY_RANGE; g++) begin : g_dmod
    assign dmod_tab[g] = SLOT_W'(g % WHEEL_SIZE);
  end

  assign dmod     = dmod_tab[cmd_delay];
  assign add_sum  = {1'b0, pos} + {1'b0, dmod};
  assign add_slot = (add_sum >= (SLOT_W+1)'(WHEEL_SIZE)) ?
                    SLOT_W'(add_sum - (SLOT_W+1)'(WHEEL_SIZE)) : SLOT_W'(add_sum);
  assign pos_next = (pos == SLOT_W'(WHEEL_SIZE - 1)) ? '0 : pos + SLOT_W'(1);

  // row of timer cells linked by the priority chain
  assign chain[0] = '0;
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    hwt_cell #(
      .WHEEL_SIZE(WHEEL_SIZE),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .handle    (cmd_handle),
      .add_slot  (add_slot),
      .add_period(dmod),
      .pos       (pos),
      .pos_next  (pos_next),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .stat      (stat[i])
    );
    assign claim_vec[i] = stat[i].claim;
    assign pick_vec[i]  = stat[i].due_pick;
    assign due_vec[i]   = stat[i].due;
    assign rest_vec[i]  = stat[i].due_rest;
    assign hit_vec[i]   = stat[i].hit_now;
    assign stop_vec[i]  = stat[i].stop_hit;
  end

  // one-hot to handle encoders
  always_comb begin
    claim_id = '0;
    pick_id  = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (claim_vec[i]) begin
        claim_id = claim_id | hwt_pkg::HANDLE_W'(i);
      end
      if (pick_vec[i]) begin
        pick_id = pick_id | hwt_pkg::HANDLE_W'(i);
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hwt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, cell commands and result selection
  always_comb begin
    state_next = state;
    ctrl       = '0;
    ctrl.rep   = cmd_rep;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    res_status = hwt_pkg::ST_NO_EXPIRY;
    res_id     = '0;
    res_last   = 1'b1;
    unique case (state)
      hwt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (op == hwt_pkg::OP_ADD || op == hwt_pkg::OP_STOP ||
                         op == hwt_pkg::OP_TICK)) begin
          state_next = hwt_pkg::S_EXEC;
        end
      end
      hwt_pkg::S_EXEC: begin
        unique case (cmd_op)
          hwt_pkg::OP_ADD: begin
            if (out_free) begin
              ctrl.add_en = 1'b1;
              out_load    = 1'b1;
              state_next  = hwt_pkg::S_IDLE;
              if (chain[NUM_TIMERS].free_seen) begin
                res_status = hwt_pkg::ST_ADDED;
                res_id     = claim_id;
              end else begin
                res_status = hwt_pkg::ST_FULL;
              end
            end
          end
          hwt_pkg::OP_STOP: begin
            if (out_free) begin
              ctrl.stop_en = 1'b1;
              out_load     = 1'b1;
              state_next   = hwt_pkg::S_IDLE;
              if (|stop_vec) begin
                res_status = hwt_pkg::ST_STOPPED;
                res_id     = cmd_handle;
              end else begin
                res_status = hwt_pkg::ST_NOT_ARMED;
              end
            end
          end
          hwt_pkg::OP_TICK: begin
            ctrl.tick_en = 1'b1;
            state_next   = hwt_pkg::S_DRAIN;
          end
          default: begin
            state_next = hwt_pkg::S_IDLE;
          end
        endcase
      end
      hwt_pkg::S_DRAIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (tick_none) begin
            state_next = hwt_pkg::S_IDLE;
          end else begin
            ctrl.emit_en = 1'b1;
            res_status   = hwt_pkg::ST_EXPIRED;
            res_id       = pick_id;
            res_last     = !(|rest_vec);
            if (!(|rest_vec)) begin
              state_next = hwt_pkg::S_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = hwt_pkg::S_IDLE;
      end
    endcase
  end

  // command capture on input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_op     <= op;
      cmd_delay  <= delay;
      cmd_rep    <= repeat_req;
      cmd_handle <= handle;
    end
  end

  // wheel position and empty-tick flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (ctrl.tick_en) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tick_en) begin
      tick_none <= !(|hit_vec);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status   <= res_status;
      timer_id <= res_id;
      last     <= res_last;
    end
  end

  // at most one cell claims a free handle or emits an expiry
  a_claim_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(claim_vec))
    else $error("more than one cell claims a free handle");

  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pick_vec))
    else $error("more than one pending expiry selected");

  // draining with expiries means some cell still has one pending
  a_drain_has_due: assert property (@(posedge clk) disable iff (rst)
    (state == hwt_pkg::S_DRAIN && !tick_none) |-> (|due_vec))
    else $error("drain with no pending expiry");

  // no expiry is left behind once the sequencer is idle
  a_idle_no_due: assert property (@(posedge clk) disable iff (rst)
    (state == hwt_pkg::S_IDLE) |-> !(|due_vec))
    else $error("pending expiry while idle");

  // a tick always advances the wheel by one slot
  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    ctrl.tick_en |=> (pos == $past(pos_next)))
    else $error("wheel position did not advance on tick");

endmodule

`default_nettype wire

FILE: test/tb_hashed_timer_wheel.sv
// self-checking testbench for the hashed timer wheel: directed table, random traffic, scoreboard
module tb_hashed_timer_wheel;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMERS = 32;
  localparam int WHEEL = 64;
  localparam int SLOT_W = $clog2(WHEEL);
  localparam int CYCLE_LIMIT = 500_000;
  localparam int LONG_HOLD = 300;
  localparam logic [hwt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [hwt_pkg::STATUS_W-1:0] st;
    logic [hwt_pkg::HANDLE_W-1:0] id;
    logic                         fin;
  } wheel_result_t;

  typedef struct packed {
    logic [hwt_pkg::OP_W-1:0]     op;
    logic [hwt_pkg::DELAY_W-1:0]  dly;
    logic                         rep;
    logic [hwt_pkg::HANDLE_W-1:0] hdl;
    logic                         typed;
    logic [hwt_pkg::STATUS_W-1:0] st;
    logic [hwt_pkg::HANDLE_W-1:0] id;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [hwt_pkg::OP_W-1:0] op = '0;
  logic [hwt_pkg::DELAY_W-1:0] delay = '0;
  logic repeat_req = 1'b0;
  logic [hwt_pkg::HANDLE_W-1:0] handle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [hwt_pkg::STATUS_W-1:0] status;
  logic [hwt_pkg::HANDLE_W-1:0] timer_id;
  logic last;

  hashed_timer_wheel #(
    .NUM_TIMERS(TIMERS),
    .WHEEL_SIZE(WHEEL)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .delay(delay),
    .repeat_req(repeat_req),
    .handle(handle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .timer_id(timer_id),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the wheel
  logic              armed [TIMERS];
  logic [SLOT_W-1:0] slot_of [TIMERS];
  logic [SLOT_W-1:0] period_of [TIMERS];
  logic              rearm [TIMERS];
  logic [SLOT_W-1:0] cur_pos;

  wheel_result_t step_results[$];
  wheel_result_t expected_results[$];
  int fails = 0;
  int got_count = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  plan_row_t plan [0:18];

  // apply one command to the shadow wheel, results land in step_results
  function automatic void timer_wheel_step(input logic [hwt_pkg::OP_W-1:0] o,
                                           input logic [hwt_pkg::DELAY_W-1:0] d,
                                           input logic r,
                                           input logic [hwt_pkg::HANDLE_W-1:0] h);
    logic fired [TIMERS];
    bit found;
    found = 1'b0;
    step_results.delete();
    case (o)
      hwt_pkg::OP_ADD: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (!found && !armed[i]) begin
            found = 1'b1;
            armed[i] = 1'b1;
            period_of[i] = SLOT_W'(d);
            rearm[i] = r;
            slot_of[i] = SLOT_W'((int'(cur_pos) + int'(d)) % WHEEL);
            step_results.push_back('{hwt_pkg::ST_ADDED, hwt_pkg::HANDLE_W'(i), 1'b1});
          end
        end
        if (!found) step_results.push_back('{hwt_pkg::ST_FULL, '0, 1'b1});
      end
      hwt_pkg::OP_STOP: begin
        if (int'(h) < TIMERS && armed[h]) begin
          armed[h] = 1'b0;
          step_results.push_back('{hwt_pkg::ST_STOPPED, h, 1'b1});
        end else begin
          step_results.push_back('{hwt_pkg::ST_NOT_ARMED, '0, 1'b1});
        end
      end
      hwt_pkg::OP_TICK: begin
        // due set is taken before any re-arm
        for (int i = 0; i < TIMERS; i++) fired[i] = armed[i] && slot_of[i] == cur_pos;
        for (int i = 0; i < TIMERS; i++) begin
          if (fired[i]) begin
            step_results.push_back('{hwt_pkg::ST_EXPIRED, hwt_pkg::HANDLE_W'(i), 1'b0});
            if (rearm[i])
              slot_of[i] = SLOT_W'((int'(cur_pos) + 1 + int'(period_of[i])) % WHEEL);
            else
              armed[i] = 1'b0;
          end
        end
        if (step_results.size() == 0)
          step_results.push_back('{hwt_pkg::ST_NO_EXPIRY, '0, 1'b1});
        else
          step_results[step_results.size() - 1].fin = 1'b1;
        cur_pos = SLOT_W'((int'(cur_pos) + 1) % WHEEL);
      end
      default: ;
    endcase
  endfunction

  // offer one command, wait for its transfer, then queue what it should produce
  task automatic offer(input logic [hwt_pkg::OP_W-1:0] o,
                       input logic [hwt_pkg::DELAY_W-1:0] d, input logic r,
                       input logic [hwt_pkg::HANDLE_W-1:0] h, input bit typed,
                       input logic [hwt_pkg::STATUS_W-1:0] st,
                       input logic [hwt_pkg::HANDLE_W-1:0] id);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    delay <= d;
    repeat_req <= r;
    handle <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    timer_wheel_step(o, d, r, h);
    if (typed)
      expected_results.push_back('{st, id, 1'b1});
    else
      foreach (step_results[k]) expected_results.push_back(step_results[k]);
  endtask

  // mixed traffic, short delays and low handles favored so timers fire and stops hit
  task automatic offer_mixed(input int count);
    logic [hwt_pkg::OP_W-1:0] o;
    logic [hwt_pkg::DELAY_W-1:0] d;
    logic [hwt_pkg::HANDLE_W-1:0] h;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) o = hwt_pkg::OP_ADD;
      else if (sel < 60) o = hwt_pkg::OP_STOP;
      else if (sel < 95) o = hwt_pkg::OP_TICK;
      else o = OP_UNUSED;
      d = ($urandom_range(0, 1) == 0) ? hwt_pkg::DELAY_W'($urandom_range(0, 7))
                                       : hwt_pkg::DELAY_W'($urandom_range(0, 63));
      h = ($urandom_range(0, 9) < 7) ? hwt_pkg::HANDLE_W'($urandom_range(0, 7))
                                      : hwt_pkg::HANDLE_W'($urandom_range(0, 31));
      offer(o, d, 1'($urandom_range(0, 1)), h, 1'b0, hwt_pkg::ST_ADDED, '0);
    end
  endtask

  // stimulus
  initial begin : stimulus
    for (int i = 0; i < TIMERS; i++) begin
      armed[i] = 1'b0;
      slot_of[i] = '0;
      period_of[i] = '0;
      rearm[i] = 1'b0;
    end
    cur_pos = '0;

    plan = '{
      '{hwt_pkg::OP_TICK, 6'd0,  1'b0, 5'd0,  1'b1, hwt_pkg::ST_NO_EXPIRY, 5'd0},
      '{hwt_pkg::OP_STOP, 6'd0,  1'b0, 5'd0,  1'b1, hwt_pkg::ST_NOT_ARMED, 5'd0},
      '{hwt_pkg::OP_STOP, 6'd63, 1'b1, 5'd31, 1'b1, hwt_pkg::ST_NOT_ARMED, 5'd0},
      '{hwt_pkg::OP_ADD,  6'd0,  1'b0, 5'd0,  1'b1, hwt_pkg::ST_ADDED,     5'd0},
      '{hwt_pkg::OP_ADD,  6'd63, 1'b1, 5'd0,  1'b1, hwt_pkg::ST_ADDED,     5'd1},
      '{hwt_pkg::OP_ADD,  6'd1,  1'b1, 5'd0,  1'b1, hwt_pkg::ST_ADDED,     5'd2},
      '{hwt_pkg::OP_ADD,  6'd1,  1'b0, 5'd31, 1'b1, hwt_pkg::ST_ADDED,     5'd3},
      '{hwt_pkg::OP_TICK, 6'd0,  1'b0, 5'd0,  1'b0, hwt_pkg::ST_ADDED,     5'd0},
      '{hwt_pkg::OP_TICK, 6'd63, 1'b1, 5'd31, 1'b0, hwt_pkg::ST_ADDED,     5'd0},
      '{hwt_pkg::OP_STOP, 6'd0,  1'b0, 5'd2,  1'b1, hwt_pkg::ST_STOPPED,   5'd2},
      '{hwt_pkg::OP_STOP, 6'd0,  1'b0, 5'd2,  1'b1, hwt_pkg::ST_NOT_ARMED, 5'd0},
      '{OP_UNUSED,        6'd63, 1'b1, 5'd31, 1'b0, hwt_pkg::ST_ADDED,     5'd0},
      '{hwt_pkg::OP_ADD,  6'd0,  1'b1, 5'd0,  1'b1, hwt_pkg::ST_ADDED,     5'd0},
      '{hwt_pkg::OP_TICK, 6'd0,  1'b0, 5'd0,  1'b0, hwt_pkg::ST_ADDED,     5'd0},
      '{hwt_pkg::OP_TICK, 6'd0,  1'b0, 5'd0,  1'b0, hwt_pkg::ST_ADDED,     5'd0},
      '{hwt_pkg::OP_STOP, 6'd0,  1'b0, 5'd0,  1'b1, hwt_pkg::ST_STOPPED,   5'd0},
      '{hwt_pkg::OP_ADD,  6'd42, 1'b0, 5'd21, 1'b1, hwt_pkg::ST_ADDED,     5'd0},
      '{OP_UNUSED,        6'd0,  1'b0, 5'd0,  1'b0, hwt_pkg::ST_ADDED,     5'd0},
      '{hwt_pkg::OP_TICK, 6'd0,  1'b0, 5'd0,  1'b0, hwt_pkg::ST_ADDED,     5'd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[k])
      offer(plan[k].op, plan[k].dly, plan[k].rep, plan[k].hdl, plan[k].typed,
            plan[k].st, plan[k].id);

    offer_mixed(60);

    // clear every handle, overfill one slot, then tick round to it
    for (int h = 0; h < TIMERS; h++)
      offer(hwt_pkg::OP_STOP, hwt_pkg::DELAY_W'($urandom_range(0, 63)),
            1'($urandom_range(0, 1)), hwt_pkg::HANDLE_W'(h), 1'b0, hwt_pkg::ST_ADDED, '0);
    repeat (TIMERS + 2)
      offer(hwt_pkg::OP_ADD, 6'd63, 1'($urandom_range(0, 1)),
            hwt_pkg::HANDLE_W'($urandom_range(0, 31)), 1'b0, hwt_pkg::ST_ADDED, '0);
    repeat (WHEEL + 1)
      offer(hwt_pkg::OP_TICK, hwt_pkg::DELAY_W'($urandom_range(0, 63)),
            1'($urandom_range(0, 1)), hwt_pkg::HANDLE_W'($urandom_range(0, 31)),
            1'b0, hwt_pkg::ST_ADDED, '0);

    offer_mixed(30);
    // closing stretch at full rate
    idle_on = 1'b0;
    offer_mixed(40);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0)
      $display("tb_hashed_timer_wheel: PASS");
    else
      $display("tb_hashed_timer_wheel: FAIL");
    $finish;
  end

  // result side: check each transfer, then pick next ready
  initial begin : result_side
    wheel_result_t want;
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got_count++;
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d timer_id %0d last %0d",
                 status, timer_id, last);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fails++;
          end
          if (timer_id !== want.id) begin
            $error("timer_id: expected %0d, got %0d", want.id, timer_id);
            fails++;
          end
          if (last !== want.fin) begin
            $error("last: expected %0d, got %0d", want.fin, last);
            fails++;
          end
        end
      end
      // one long hold so the input side backs up
      if (!held && got_count >= 40) begin
        held = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_hashed_timer_wheel: FAIL");
      $finish;
    end
  end

endmodule
